>>> sv/als_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the addressable LED serializer.
// No dependencies; used by the top level and als_engine.
package als_pkg;

	localparam int MAX_LEDS_DEF = 256;
	localparam int WORD_W       = 24;
	localparam int BITS_PER_LED = 24;
	localparam int CNT_W        = 9;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_SET    = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LED_COUNT  = 3'd0,
		REG_ZERO_HIGH  = 3'd1,
		REG_ZERO_LOW   = 3'd2,
		REG_ONE_HIGH   = 3'd3,
		REG_ONE_LOW    = 3'd4,
		REG_LATCH_LOW  = 3'd5
	} cfg_reg_e;

	localparam logic [CNT_W-1:0] LED_COUNT_RST  = 9'd1;
	localparam logic [7:0]       ZERO_HIGH_RST  = 8'd3;
	localparam logic [7:0]       ZERO_LOW_RST   = 8'd9;
	localparam logic [7:0]       ONE_HIGH_RST   = 8'd9;
	localparam logic [7:0]       ONE_LOW_RST    = 8'd3;
	localparam logic [15:0]      LATCH_LOW_RST  = 16'd500;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] led_index;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
	} in_item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] led_count;
		logic [7:0]       zero_high_ticks;
		logic [7:0]       zero_low_ticks;
		logic [7:0]       one_high_ticks;
		logic [7:0]       one_low_ticks;
		logic [15:0]      latch_low_ticks;
	} cfg_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEND,
		PH_LATCH
	} phase_e;

	function automatic logic [7:0] min_one8(input logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	function automatic logic [15:0] min_one16(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

endpackage

>>> sv/addressable_led_serializer.sv
`timescale 1ns / 1ps
// Top level of the addressable LED serializer: config registers, output register.
// Depends on als_pkg and als_engine.
//
// Usage:
//   Input beats (in_valid/in_stall, in_data) carry a command: tick, set_color,
//   update or clear. Each accepted beat yields exactly one result beat
//   (out_valid/out_stall, out_data) with the line level, busy and frame_done.
//   One beat per clock is taken while in_stall is low; results are registered
//   and shown in the cycle after their beat. The pixel store is a one-port-read
//   RAM with registered read; the fetched LED word goes straight into the bit
//   shifter, so a tick may follow a frame start or an LED change immediately.
//   A frame lasts sum of bit high/low ticks over led_count * 24 bits, plus
//   latch_low_ticks; set_color, update and clear are ignored while busy. The
//   user must write configuration (cfg_we, cfg_index, cfg_wdata) while idle; the
//   block does not enforce it. Reset: registers but out_data take defaults, every
//   pixel reads as zero at once (per-entry valid bits); no clearing pass is needed.
//   When out_stall is high with a result held, in_stall rises in the same
//   cycle and no beat is lost; a result taken this cycle frees the slot.
module addressable_led_serializer #(
	parameter int MAX_LEDS = als_pkg::MAX_LEDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  als_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output als_pkg::out_item_t                  out_data,
	input  logic                                cfg_we,
	input  logic [als_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [als_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	als_pkg::cfg_t      cfg_q;
	als_pkg::out_item_t result;
	als_pkg::out_item_t out_data_q;
	logic               out_valid_q;
	logic               item_go;

	assign in_stall = out_valid_q && out_stall;
	assign item_go  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_count       <= als_pkg::LED_COUNT_RST;
			cfg_q.zero_high_ticks <= als_pkg::ZERO_HIGH_RST;
			cfg_q.zero_low_ticks  <= als_pkg::ZERO_LOW_RST;
			cfg_q.one_high_ticks  <= als_pkg::ONE_HIGH_RST;
			cfg_q.one_low_ticks   <= als_pkg::ONE_LOW_RST;
			cfg_q.latch_low_ticks <= als_pkg::LATCH_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				als_pkg::REG_LED_COUNT: cfg_q.led_count <= cfg_wdata[als_pkg::CNT_W-1:0];
				als_pkg::REG_ZERO_HIGH: cfg_q.zero_high_ticks <= cfg_wdata[7:0];
				als_pkg::REG_ZERO_LOW:  cfg_q.zero_low_ticks <= cfg_wdata[7:0];
				als_pkg::REG_ONE_HIGH:  cfg_q.one_high_ticks <= cfg_wdata[7:0];
				als_pkg::REG_ONE_LOW:   cfg_q.one_low_ticks <= cfg_wdata[7:0];
				als_pkg::REG_LATCH_LOW: cfg_q.latch_low_ticks <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	als_engine #(
		.MAX_LEDS (MAX_LEDS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_go (item_go),
		.item    (in_data),
		.cfg     (cfg_q),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_go) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> sv/als_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first on a same-address collision. No dependencies.
module als_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/als_engine.sv
`timescale 1ns / 1ps
// Frame sequencer: pixel store (RAM plus per-entry valid bits) and bit timing.
// Depends on als_pkg and als_ram.
module als_engine #(
	parameter int MAX_LEDS = als_pkg::MAX_LEDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_go,
	input  als_pkg::in_item_t    item,
	input  als_pkg::cfg_t        cfg,
	output als_pkg::out_item_t   result
);

	// Only DEPTH (at most 256) entries can be written; positions past that read as zero.
	localparam int DEPTH   = (MAX_LEDS < 256) ? MAX_LEDS : 256;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EFF_CAP = (MAX_LEDS < 511) ? MAX_LEDS : 511;
	localparam int POS_LIM = (MAX_LEDS < 512) ? MAX_LEDS : 512;
	localparam int POS_W   = (POS_LIM > 1) ? $clog2(POS_LIM) : 1;
	localparam int CW      = als_pkg::CNT_W;

	als_pkg::phase_e state_q, state_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [4:0]        bit_q, bit_d;
	logic              high_q, high_d;
	logic [15:0]       tick_q, tick_d;
	logic              clear_q, clear_d;
	logic [als_pkg::WORD_W-1:0] shift_q;
	logic              load_s1;
	logic              rd_hit_s1;
	logic [DEPTH-1:0]  valid_q;

	logic [als_pkg::WORD_W-1:0] ram_rdata, cur_word, next_word;
	logic [CW-1:0]     eff_cnt;
	logic              cur_bit, last_led, idx_ok, rd_in_range;
	logic              do_shift, load, set_we, level, done;
	logic [7:0]        dur8;
	logic [16:0]       cnt_inc;
	logic [AW-1:0]     rd_idx, wr_idx;

	always_comb begin
		if (cfg.led_count == '0) begin
			eff_cnt = CW'(1);
		end else if (cfg.led_count > CW'(EFF_CAP)) begin
			eff_cnt = CW'(EFF_CAP);
		end else begin
			eff_cnt = cfg.led_count;
		end
	end

	// While load_s1 is set, the word fetched at the last edge is the RAM read data.
	assign cur_word = load_s1 ? (rd_hit_s1 ? ram_rdata : '0) : shift_q;
	assign cur_bit  = cur_word[als_pkg::WORD_W-1];
	assign cnt_inc  = {1'b0, tick_q} + 17'd1;
	assign last_led = ({{(10 - POS_W){1'b0}}, pos_q} + 10'd1) >= {1'b0, eff_cnt};
	assign idx_ok   = {1'b0, item.led_index} < eff_cnt;
	assign wr_idx   = item.led_index[AW-1:0];
	assign rd_idx   = pos_d[AW-1:0];
	assign rd_in_range = {1'b0, pos_d} < (POS_W + 1)'(DEPTH);

	always_comb begin
		if (high_q) begin
			dur8 = als_pkg::min_one8(cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks);
		end else begin
			dur8 = als_pkg::min_one8(cur_bit ? cfg.one_low_ticks : cfg.zero_low_ticks);
		end
	end

	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		bit_d    = bit_q;
		high_d   = high_q;
		tick_d   = tick_q;
		clear_d  = clear_q;
		do_shift = 1'b0;
		load     = 1'b0;
		set_we   = 1'b0;
		level    = 1'b0;
		done     = 1'b0;
		if (item_go) begin
			if (item.command == als_pkg::CMD_TICK) begin
				case (state_q)
					als_pkg::PH_SEND: begin
						level = high_q;
						if (cnt_inc >= {9'd0, dur8}) begin
							tick_d = '0;
							if (high_q) begin
								high_d = 1'b0;
							end else begin
								high_d   = 1'b1;
								do_shift = 1'b1;
								if (bit_q == 5'(als_pkg::BITS_PER_LED - 1)) begin
									bit_d = '0;
									if (last_led) begin
										state_d = als_pkg::PH_LATCH;
										high_d  = 1'b0;
									end else begin
										pos_d = pos_q + 1'b1;
										load  = 1'b1;
									end
								end else begin
									bit_d = bit_q + 5'd1;
								end
							end
						end else begin
							tick_d = cnt_inc[15:0];
						end
					end
					als_pkg::PH_LATCH: begin
						if (cnt_inc >= {1'b0, als_pkg::min_one16(cfg.latch_low_ticks)}) begin
							tick_d  = '0;
							state_d = als_pkg::PH_IDLE;
							clear_d = 1'b0;
							pos_d   = '0;
							done    = 1'b1;
						end else begin
							tick_d = cnt_inc[15:0];
						end
					end
					default: begin
					end
				endcase
			end else if (state_q != als_pkg::PH_IDLE) begin
				level = (state_q == als_pkg::PH_SEND) && high_q;
			end else if (item.command == als_pkg::CMD_SET) begin
				set_we = idx_ok;
			end else begin
				clear_d = (item.command == als_pkg::CMD_CLEAR);
				state_d = als_pkg::PH_SEND;
				pos_d   = '0;
				bit_d   = '0;
				high_d  = 1'b1;
				tick_d  = '0;
				load    = 1'b1;
			end
		end
	end

	assign next_word = do_shift ? {cur_word[als_pkg::WORD_W-2:0], 1'b0} : cur_word;

	assign result.line_level = level;
	assign result.busy_res   = (state_d != als_pkg::PH_IDLE);
	assign result.frame_done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= als_pkg::PH_IDLE;
			pos_q     <= '0;
			bit_q     <= '0;
			high_q    <= 1'b0;
			tick_q    <= '0;
			clear_q   <= 1'b0;
			shift_q   <= '0;
			load_s1   <= 1'b0;
			rd_hit_s1 <= 1'b0;
			valid_q   <= '0;
		end else begin
			state_q   <= state_d;
			pos_q     <= pos_d;
			bit_q     <= bit_d;
			high_q    <= high_d;
			tick_q    <= tick_d;
			clear_q   <= clear_d;
			shift_q   <= next_word;
			load_s1   <= load;
			// valid bit sampled read-first, alongside the RAM read
			rd_hit_s1 <= rd_in_range && valid_q[rd_idx];
			if (set_we) begin
				valid_q[wr_idx] <= 1'b1;
			end
			// a clear frame zeroes each entry as it is fetched
			if (load && clear_d && rd_in_range) begin
				valid_q[rd_idx] <= 1'b0;
			end
		end
	end

	als_ram #(
		.WIDTH (als_pkg::WORD_W),
		.DEPTH (DEPTH)
	) u_pixels (
		.clk   (clk),
		.we    (set_we),
		.waddr (wr_idx),
		.wdata ({item.green, item.red, item.blue}),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(item_go && result.frame_done) |=> (state_q == als_pkg::PH_IDLE))
		else $error("frame_done without return to idle");

	a_level_only_sending: assert property (@(posedge clk) disable iff (!arst_n)
		result.line_level |-> (state_q == als_pkg::PH_SEND))
		else $error("line high outside a frame");

	a_load_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |-> ($past(item_go) && (state_q == als_pkg::PH_SEND) && high_q))
		else $error("pixel fetch without a beat that started an LED");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q < 5'(als_pkg::BITS_PER_LED))
		else $error("bit position out of range");

	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == als_pkg::PH_SEND) |-> (tick_q < 16'd255))
		else $error("bit tick counter overran");

endmodule
